// ===== rtl/sbsm_pkg.sv =====
// Package: shared types and constants for the serial bank switch mapper.
package sbsm_pkg;

  localparam int unsigned RegCount  = 5;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [4:0] CtrlReset   = 5'h0C;
  localparam logic [4:0] ChrHiReset  = 5'h01;
  localparam logic [2:0] LastShift   = 3'd4;

  typedef enum logic [2:0] {
    REG_SNROM     = 3'd0,
    REG_SOROM     = 3'd1,
    REG_PRG_512K  = 3'd2,
    REG_RAM_BANKS = 3'd3,
    REG_PRG_FIXED = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_CONTROL = 2'd0,
    SEL_CHR0    = 2'd1,
    SEL_CHR1    = 2'd2,
    SEL_PRG     = 2'd3
  } reg_sel_t;

  typedef struct packed {
    logic snrom_board;
    logic sorom_board;
    logic prg_rom_512k;
    logic prg_ram_banked;
    logic prg_fixed;
  } board_cfg_t;

  typedef struct packed {
    logic [15:0] address;
    logic [7:0]  write_data;
  } sbsm_req_t;

  typedef struct packed {
    logic       ram_write;
    logic [4:0] prg_bank_low;
    logic [4:0] prg_bank_high;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] ram_bank;
    logic [1:0] mirroring;
    logic       ram_enabled;
  } sbsm_res_t;

endpackage

// ===== rtl/serial_bank_switch_mapper_unit.sv =====
// Top level: serial bank switch mapper with request and result registers.
//
// Usage:
//   in_valid/in_stall/in_req carry one CPU write per request (address, data).
//   out_valid/out_stall/out_res return one mapping result per request, in
//   order: RAM write strobe, PRG/CHR/RAM banks, mirroring and RAM enable.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready set the board options;
//   write them only while no request is in flight.
// Path: a request is held in the request register, then enters the result
//   register after the shift/decode logic.
// Throughput: one request per cycle while out_stall is low; each request
//   does its serial shifter update in combinational logic.
// Reset: rst_n low clears both pipeline valid flags, the shifter and the bank
//   registers (control 0x0C, CHR high slot 1) and all board options.
// Stall: with out_stall high the result holds; the request register keeps
//   accepting while the result register is free or being drained, and
//   in_stall rises only when both stages are full.
module serial_bank_switch_mapper_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sbsm_pkg::sbsm_req_t               in_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sbsm_pkg::sbsm_res_t               out_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbsm_pkg::AddrWidth-1:0]    paddr,
  input  logic [sbsm_pkg::DataWidth-1:0]    pwdata,
  output logic [sbsm_pkg::DataWidth-1:0]    prdata,
  output logic                              pready
);
  import sbsm_pkg::*;

  board_cfg_t cfg;

  sbsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .board_cfg (cfg)
  );

  // pipeline control
  logic      req_vld_r;
  sbsm_req_t req_r;
  logic      out_vld_r;
  sbsm_res_t res_r;
  logic      advance;

  assign advance   = req_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = req_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_res   = res_r;

  // mapper state
  logic [4:0] shifter_r, shifter_nxt;
  logic [2:0] count_r, count_nxt;
  logic [4:0] ctrl_r, ctrl_nxt;
  logic [4:0] chr0_r, chr0_nxt;
  logic [4:0] chr1_r, chr1_nxt;
  logic [4:0] prg_r, prg_nxt;
  logic [4:0] chr_lo_r, chr_lo_nxt;
  logic [4:0] chr_hi_r, chr_hi_nxt;
  logic [1:0] ram_bank_r, ram_bank_nxt;

  logic       rom_write, ram_window, update;
  logic [4:0] shift_val, c0, c1, bank, offset, sum, prg_lo, prg_hi;
  logic       ram_on;
  reg_sel_t   sel;
  sbsm_res_t  res_nxt;

  always_comb begin
    rom_write  = req_r.address[15];
    ram_window = (req_r.address[15:13] == 3'b011);
    sel        = reg_sel_t'(req_r.address[14:13]);
    shift_val  = shifter_r | 5'({4'b0, req_r.write_data[0]} << count_r);

    shifter_nxt = shifter_r;
    count_nxt   = count_r;
    ctrl_nxt    = ctrl_r;
    chr0_nxt    = chr0_r;
    chr1_nxt    = chr1_r;
    prg_nxt     = prg_r;
    update      = 1'b0;

    if (rom_write) begin
      if (req_r.write_data[7]) begin
        shifter_nxt = '0;
        count_nxt   = '0;
        ctrl_nxt    = ctrl_r | CtrlReset;
        update      = 1'b1;
      end else if (count_r == LastShift) begin
        shifter_nxt = '0;
        count_nxt   = '0;
        update      = 1'b1;
        case (sel)
          SEL_CONTROL: ctrl_nxt = shift_val;
          SEL_CHR0:    chr0_nxt = shift_val;
          SEL_CHR1:    chr1_nxt = shift_val;
          SEL_PRG:     prg_nxt  = shift_val;
          default:     prg_nxt  = shift_val;
        endcase
      end else begin
        shifter_nxt = shift_val;
        count_nxt   = count_r + 3'd1;
      end
    end

    // CHR / RAM bank latching at an update
    c0 = cfg.snrom_board ? {4'b0, chr0_nxt[0]} : chr0_nxt;
    c1 = cfg.snrom_board ? {4'b0, chr1_nxt[0]} : chr1_nxt;
    chr_lo_nxt   = chr_lo_r;
    chr_hi_nxt   = chr_hi_r;
    ram_bank_nxt = ram_bank_r;
    if (update) begin
      if (!cfg.prg_fixed && cfg.sorom_board && cfg.prg_ram_banked) begin
        ram_bank_nxt = chr0_nxt[3:2];
      end
      if (ctrl_nxt[4]) begin
        chr_lo_nxt = c0;
        chr_hi_nxt = c1;
      end else if (!cfg.snrom_board) begin
        chr_lo_nxt = {c0[4:1], 1'b0};
        chr_hi_nxt = {c0[4:1], 1'b1};
      end
    end

    ram_on = !prg_nxt[4] &&
             !(cfg.snrom_board && !cfg.sorom_board && chr0_nxt[4]);

    bank   = {1'b0, prg_nxt[3:0]};
    offset = (cfg.sorom_board && cfg.prg_rom_512k && chr0_nxt[4]) ? 5'h10 : 5'h00;
    sum    = bank + offset;
    if (cfg.prg_fixed) begin
      prg_lo = 5'd0;
      prg_hi = 5'd1;
    end else begin
      case (ctrl_nxt[3:2])
        2'd2: begin
          prg_lo = offset;
          prg_hi = sum;
        end
        2'd3: begin
          prg_lo = sum;
          prg_hi = offset | 5'h0F;
        end
        default: begin
          prg_lo = {sum[4:1], 1'b0};
          prg_hi = {sum[4:1], 1'b1};
        end
      endcase
    end

    res_nxt.ram_write     = ram_window && ram_on;
    res_nxt.prg_bank_low  = prg_lo;
    res_nxt.prg_bank_high = prg_hi;
    res_nxt.chr_bank_low  = chr_lo_nxt;
    res_nxt.chr_bank_high = chr_hi_nxt;
    res_nxt.ram_bank      = ram_bank_nxt;
    res_nxt.mirroring     = ctrl_nxt[1:0];
    res_nxt.ram_enabled   = ram_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
      shifter_r  <= '0;
      count_r    <= '0;
      ctrl_r     <= CtrlReset;
      chr0_r     <= '0;
      chr1_r     <= '0;
      prg_r      <= '0;
      chr_lo_r   <= '0;
      chr_hi_r   <= ChrHiReset;
      ram_bank_r <= '0;
    end else begin
      if (!in_stall) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r  <= 1'b1;
        shifter_r  <= shifter_nxt;
        count_r    <= count_nxt;
        ctrl_r     <= ctrl_nxt;
        chr0_r     <= chr0_nxt;
        chr1_r     <= chr1_nxt;
        prg_r      <= prg_nxt;
        chr_lo_r   <= chr_lo_nxt;
        chr_hi_r   <= chr_hi_nxt;
        ram_bank_r <= ram_bank_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_req;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/sbsm_cfg_regs.sv =====
// Board configuration register file behind the APB-style port.
module sbsm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sbsm_pkg::AddrWidth-1:0]    paddr,
  input  logic [sbsm_pkg::DataWidth-1:0]    pwdata,
  output logic [sbsm_pkg::DataWidth-1:0]    prdata,
  output logic                              pready,
  output sbsm_pkg::board_cfg_t              board_cfg
);
  import sbsm_pkg::*;

  board_cfg_t cfg_r;
  reg_idx_t   idx;
  logic       wr_en;

  assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign board_cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SNROM:     cfg_r.snrom_board    <= pwdata[0];
        REG_SOROM:     cfg_r.sorom_board    <= pwdata[0];
        REG_PRG_512K:  cfg_r.prg_rom_512k   <= pwdata[0];
        REG_RAM_BANKS: cfg_r.prg_ram_banked <= pwdata[0];
        REG_PRG_FIXED: cfg_r.prg_fixed      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SNROM:     prdata[0] = cfg_r.snrom_board;
      REG_SOROM:     prdata[0] = cfg_r.sorom_board;
      REG_PRG_512K:  prdata[0] = cfg_r.prg_rom_512k;
      REG_RAM_BANKS: prdata[0] = cfg_r.prg_ram_banked;
      REG_PRG_FIXED: prdata[0] = cfg_r.prg_fixed;
      default:       prdata    = '0;
    endcase
  end

endmodule
